// ----- src/mrl_pkg.sv -----
// Package for the minimal perfect hash lookup engine.
// Holds op codes, store geometry, hash constants, the sequencer state type
// and small helper functions. No dependencies.
`default_nettype none

package mrl_pkg;

   localparam int MAX_LEVELS   = 8;
   localparam int LEVEL_W      = 3;
   localparam int LCOUNT_W     = 4;
   localparam int WORD_AW      = 10;
   localparam int RANK_AW      = 7;
   localparam int KEY_AW       = LEVEL_W + WORD_AW;
   localparam int RANKS_AW     = LEVEL_W + RANK_AW;
   localparam int KEY_DEPTH    = 1 << KEY_AW;
   localparam int RANK_DEPTH   = 1 << RANKS_AW;

   localparam logic [1:0] OP_KEY    = 2'd0;
   localparam logic [1:0] OP_RANK   = 2'd1;
   localparam logic [1:0] OP_SIZE   = 2'd2;
   localparam logic [1:0] OP_LOOKUP = 2'd3;

   localparam logic [31:0] MIX_C1  = 32'hCC9E2D51;
   localparam logic [31:0] MIX_C2  = 32'h1B873593;
   localparam logic [31:0] MIX_ADD = 32'hE6546B64;
   localparam logic [31:0] FIN_C1  = 32'h85EBCA6B;
   localparam logic [31:0] FIN_C2  = 32'hC2B2AE35;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIX0,
      ST_MIX1,
      ST_LEVEL,
      ST_HASH1,
      ST_HASH2,
      ST_HASH3,
      ST_HASH4,
      ST_DIV,
      ST_KREAD,
      ST_KCHECK,
      ST_RANK,
      ST_POP,
      ST_RESP
   } state_type;

   function automatic logic [31:0] rotl13(input logic [31:0] x);
      return {x[18:0], x[31:19]};
   endfunction

   function automatic logic [31:0] rotl15(input logic [31:0] x);
      return {x[16:0], x[31:17]};
   endfunction

   function automatic logic [6:0] popcount64(input logic [63:0] x);
      logic [6:0] n;
      n = 7'd0;
      for (int i = 0; i < 64; i++) begin
         n = n + 7'(x[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- src/mph_rank_index_lookup.sv -----
// Minimal perfect hash lookup engine: sequencer, key bit and rank memories.
// Depends on mrl_pkg.
//
// Usage: req_* carries one item per handshake. Ops 0..2 load a key bit word,
// a rank entry or a level size; op 3 looks up req_scalar. Every item gives
// exactly one rsp_* item: writes return index 0, hit 0; a lookup returns the
// rank of its bit in the first level that holds it, or index 0, hit 0.
// csr_we/csr_wdata set the number of levels searched (above 8 acts as 8).
// A write goes straight to the response. A lookup skips an empty level; for any
// other level it hashes, takes the remainder by the level size and reads the key
// word; on a hit it adds the rank entry, the popcount of the earlier words in its
// group of 8 and that of the lower bits of its own word. The remainder unit is
// radix-4, and the popcount reads the key memory through its single read port,
// one word a cycle.
// One item is worked on at a time; a new item is taken while the previous
// result still waits in the output register.
// Reset clears level sizes, level count and control; key and rank memories
// hold no reset value and must be written before they are read. When the
// receiver stalls, the result holds and the next finished item waits.
`default_nettype none

module mph_rank_index_lookup (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [1:0]                    req_op,
   input  wire logic [2:0]                    req_level_sel,
   input  wire logic [9:0]                    req_entry_addr,
   input  wire logic [63:0]                   req_write_data,
   input  wire logic [31:0]                   req_scalar,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [15:0]                   rsp_index,
   output      logic                          rsp_hit,
   input  wire logic                          csr_we,
   input  wire logic [mrl_pkg::LCOUNT_W-1:0]  csr_wdata
);
   import mrl_pkg::*;

   logic [63:0] key_mem [KEY_DEPTH];
   logic [15:0] rank_mem [RANK_DEPTH];

   state_type              state_ff, state_in;
   logic [LCOUNT_W-1:0]    level_count_ff;
   logic [15:0]            level_size_ff [MAX_LEVELS];
   logic [LCOUNT_W-1:0]    lvl_ff, lvl_in;
   logic [LCOUNT_W-1:0]    levels_ff, levels_in;
   logic [31:0]            scalar_ff, scalar_in;
   logic [31:0]            ks_ff, ks_in;
   logic [31:0]            t_ff, t_in;
   logic [31:0]            h_ff, h_in;
   logic [15:0]            rem_ff, rem_in;
   logic [15:0]            size_ff, size_in;
   logic [3:0]             div_cnt_ff, div_cnt_in;
   logic [15:0]            acc_ff, acc_in;
   logic [2:0]             j_ff, j_in;
   logic [15:0]            res_index_ff, res_index_in;
   logic                   res_hit_ff, res_hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_index_ff, rsp_index_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [63:0]            key_q_ff;
   logic [15:0]            rank_q_ff;

   logic                   key_we, rank_we, size_we;
   logic [KEY_AW-1:0]      key_raddr;
   logic [RANKS_AW-1:0]    rank_raddr;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_hit   = rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[{req_level_sel, req_entry_addr}] <= req_write_data;
      end
      key_q_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[{req_level_sel, req_entry_addr[RANK_AW-1:0]}] <= req_write_data[15:0];
      end
      rank_q_ff <= rank_mem[rank_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         level_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            level_size_ff[i] <= 16'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            level_count_ff <= csr_wdata;
         end
         if (size_we) begin
            level_size_ff[req_level_sel] <= req_write_data[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      levels_ff    <= levels_in;
      scalar_ff    <= scalar_in;
      ks_ff        <= ks_in;
      t_ff         <= t_in;
      h_ff         <= h_in;
      rem_ff       <= rem_in;
      size_ff      <= size_in;
      div_cnt_ff   <= div_cnt_in;
      acc_ff       <= acc_in;
      j_ff         <= j_in;
      res_index_ff <= res_index_in;
      res_hit_ff   <= res_hit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   always_comb begin
      logic [31:0] x;
      logic [31:0] p;
      logic [16:0] r1;
      logic [16:0] r2;
      logic [15:0] sz;
      logic [63:0] mask;
      logic [15:0] a;

      state_in     = state_ff;
      lvl_in       = lvl_ff;
      levels_in    = levels_ff;
      scalar_in    = scalar_ff;
      ks_in        = ks_ff;
      t_in         = t_ff;
      h_in         = h_ff;
      rem_in       = rem_ff;
      size_in      = size_ff;
      div_cnt_in   = div_cnt_ff;
      acc_in       = acc_ff;
      j_in         = j_ff;
      res_index_in = res_index_ff;
      res_hit_in   = res_hit_ff;
      rsp_index_in = rsp_index_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_we       = 1'b0;
      rank_we      = 1'b0;
      size_we      = 1'b0;
      key_raddr    = {lvl_ff[LEVEL_W-1:0], rem_ff[15:6]};
      rank_raddr   = {lvl_ff[LEVEL_W-1:0], rem_ff[15:9]};
      x            = 32'd0;
      p            = 32'd0;
      r1           = 17'd0;
      r2           = 17'd0;
      sz           = level_size_ff[lvl_ff[LEVEL_W-1:0]];
      mask         = (64'd1 << rem_ff[5:0]) - 64'd1;
      a            = acc_ff + 16'(popcount64(key_q_ff));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_index_in = 16'd0;
               res_hit_in   = 1'b0;
               state_in     = ST_RESP;
               unique case (req_op)
                  OP_KEY:  key_we  = 1'b1;
                  OP_RANK: rank_we = 1'b1;
                  OP_SIZE: size_we = 1'b1;
                  default: begin
                     scalar_in = req_scalar;
                     lvl_in    = '0;
                     levels_in = (level_count_ff > LCOUNT_W'(MAX_LEVELS)) ?
                                 LCOUNT_W'(MAX_LEVELS) : level_count_ff;
                     state_in  = ST_MIX0;
                  end
               endcase
            end
         end
         ST_MIX0: begin
            p        = scalar_ff * MIX_C1;
            t_in     = rotl15(p);
            state_in = ST_MIX1;
         end
         ST_MIX1: begin
            ks_in    = t_ff * MIX_C2;
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            if (lvl_ff >= levels_ff) begin
               state_in = ST_RESP;
            end else if (sz == 16'd0) begin
               lvl_in = lvl_ff + LCOUNT_W'(1);
            end else begin
               size_in  = sz;
               p        = {16'd0, sz} * MIX_C1;
               t_in     = rotl15(p);
               state_in = ST_HASH1;
            end
         end
         ST_HASH1: begin
            t_in     = t_ff * MIX_C2;
            x        = rotl13(ks_ff ^ {28'd0, lvl_ff});
            h_in     = (x << 2) + x + MIX_ADD;
            state_in = ST_HASH2;
         end
         ST_HASH2: begin
            x        = rotl13(h_ff ^ t_ff);
            x        = ((x << 2) + x + MIX_ADD) ^ 32'd8;
            h_in     = x ^ (x >> 16);
            state_in = ST_HASH3;
         end
         ST_HASH3: begin
            p        = h_ff * FIN_C1;
            h_in     = p ^ (p >> 13);
            state_in = ST_HASH4;
         end
         ST_HASH4: begin
            p          = h_ff * FIN_C2;
            h_in       = p ^ (p >> 16);
            rem_in     = 16'd0;
            div_cnt_in = 4'd0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            r1 = {rem_ff, h_ff[31]};
            if (r1 >= {1'b0, size_ff}) begin
               r1 = r1 - {1'b0, size_ff};
            end
            r2 = {r1[15:0], h_ff[30]};
            if (r2 >= {1'b0, size_ff}) begin
               r2 = r2 - {1'b0, size_ff};
            end
            rem_in     = r2[15:0];
            h_in       = {h_ff[29:0], 2'b00};
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'd15) begin
               state_in = ST_KREAD;
            end
         end
         ST_KREAD: begin
            state_in = ST_KCHECK;
         end
         ST_KCHECK: begin
            if (key_q_ff[rem_ff[5:0]]) begin
               acc_in   = 16'(popcount64(key_q_ff & mask));
               state_in = ST_RANK;
            end else begin
               lvl_in   = lvl_ff + LCOUNT_W'(1);
               state_in = ST_LEVEL;
            end
         end
         ST_RANK: begin
            acc_in = acc_ff + rank_q_ff;
            if (rem_ff[8:6] == 3'd0) begin
               res_index_in = acc_ff + rank_q_ff;
               res_hit_in   = 1'b1;
               state_in     = ST_RESP;
            end else begin
               key_raddr = {lvl_ff[LEVEL_W-1:0], rem_ff[15:9], 3'd0};
               j_in      = 3'd0;
               state_in  = ST_POP;
            end
         end
         ST_POP: begin
            acc_in = a;
            if (3'(j_ff + 3'd1) == rem_ff[8:6]) begin
               res_index_in = a;
               res_hit_in   = 1'b1;
               state_in     = ST_RESP;
            end else begin
               key_raddr = {lvl_ff[LEVEL_W-1:0], rem_ff[15:9], 3'(j_ff + 3'd1)};
               j_in      = 3'(j_ff + 3'd1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_index_ff;
               rsp_hit_in   = res_hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for mph_rank_index_lookup: table loads and lookups with
// random gaps and stalls, checked against an in-bench hash and rank predictor.
// Depends on mrl_pkg and the mph_rank_index_lookup RTL.
`default_nettype none

module tb;
   import mrl_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;

   typedef struct packed {
      logic [15:0] index;
      logic        hit;
   } lookup_result_type;

   typedef enum int {MISS_NONE, MISS_KEY, MISS_RANK} miss_kind_type;

   class rank_scoreboard;
      logic [63:0]       key_mem[int];
      logic [15:0]       rank_mem[int];
      logic [15:0]       sizes[MAX_LEVELS];
      logic [3:0]        lcount;
      lookup_result_type pending[$];
      int                errors;

      function new();
         foreach (sizes[i]) sizes[i] = '0;
         lcount = '0;
         errors = 0;
      endfunction

      function logic [31:0] mix_word(input logic [31:0] k);
         k = k * MIX_C1;
         k = {k[16:0], k[31:17]};
         return k * MIX_C2;
      endfunction

      function logic [31:0] bit_position(input logic [31:0] scalar, input logic [15:0] size,
                                         input logic [31:0] seed);
         logic [31:0] h;
         h = seed ^ mix_word(scalar);
         h = {h[18:0], h[31:19]};
         h = h * 32'd5 + MIX_ADD;
         h = h ^ mix_word({16'd0, size});
         h = {h[18:0], h[31:19]};
         h = h * 32'd5 + MIX_ADD;
         h = h ^ 32'd8;
         h = h ^ (h >> 16);
         h = h * FIN_C1;
         h = h ^ (h >> 13);
         h = h * FIN_C2;
         h = h ^ (h >> 16);
         return h % {16'd0, size};
      endfunction

      function void resolve(input logic [31:0] scalar, output miss_kind_type miss,
                            output int miss_addr, output lookup_result_type res);
         int          levels;
         logic [31:0] pos;
         int          widx;
         int          b;
         int          ka;
         int          ra;
         logic [63:0] word;
         logic [31:0] rank;
         levels = (lcount > MAX_LEVELS) ? MAX_LEVELS : lcount;
         res = '0;
         miss = MISS_NONE;
         miss_addr = 0;
         for (int i = 0; i < levels; i++) begin
            if (sizes[i] == 0) continue;
            pos = bit_position(scalar, sizes[i], i);
            widx = pos / 64;
            b = pos % 64;
            ka = i * 1024 + widx;
            if (!key_mem.exists(ka)) begin
               miss = MISS_KEY;
               miss_addr = ka;
               return;
            end
            word = key_mem[ka];
            if (!word[b]) continue;
            ra = i * 128 + widx / 8;
            if (!rank_mem.exists(ra)) begin
               miss = MISS_RANK;
               miss_addr = ra;
               return;
            end
            rank = {16'd0, rank_mem[ra]};
            for (int j = widx & ~7; j < widx; j++) begin
               if (!key_mem.exists(i * 1024 + j)) begin
                  miss = MISS_KEY;
                  miss_addr = i * 1024 + j;
                  return;
               end
               rank = rank + $countones(key_mem[i * 1024 + j]);
            end
            if (b > 0) rank = rank + $countones(word & ((64'd1 << b) - 64'd1));
            res.index = rank[15:0];
            res.hit = 1'b1;
            return;
         end
      endfunction

      function void note_item(input logic [1:0] op, input logic [2:0] lsel,
                              input logic [9:0] addr, input logic [63:0] data,
                              input logic [31:0] scalar);
         lookup_result_type res;
         miss_kind_type     miss;
         int                miss_addr;
         res = '0;
         case (op)
            OP_KEY:  key_mem[lsel * 1024 + addr] = data;
            OP_RANK: rank_mem[lsel * 128 + addr[6:0]] = data[15:0];
            OP_SIZE: sizes[lsel] = data[15:0];
            default: resolve(scalar, miss, miss_addr, res);
         endcase
         pending.push_back(res);
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(input logic [15:0] index, input logic hit);
         lookup_result_type exp;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result index=%0h hit=%0b", index, hit));
         end else begin
            exp = pending.pop_front();
            if (index !== exp.index)
               report($sformatf("index %0h, expected %0h", index, exp.index));
            if (hit !== exp.hit)
               report($sformatf("hit %0b, expected %0b", hit, exp.hit));
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_op = OP_KEY;
   logic [2:0]          req_level_sel = '0;
   logic [9:0]          req_entry_addr = '0;
   logic [63:0]         req_write_data = '0;
   logic [31:0]         req_scalar = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [15:0]         rsp_index;
   logic                rsp_hit;
   logic                csr_we = 1'b0;
   logic [LCOUNT_W-1:0] csr_wdata = '0;

   rank_scoreboard sb = new();
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             idle_cycles = 0;
   int             item_count = 0;
   logic [31:0]    seen_scalars[$];

   mph_rank_index_lookup i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_level_sel  (req_level_sel),
      .req_entry_addr (req_entry_addr),
      .req_write_data (req_write_data),
      .req_scalar     (req_scalar),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_index      (rsp_index),
      .rsp_hit        (rsp_hit),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_index, rsp_hit);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** mph_rank_index_lookup: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function logic [63:0] key_word();
      case ($urandom_range(3))
         0:       return '1;
         1:       return {$urandom, $urandom};
         default: return {$urandom, $urandom} | {$urandom, $urandom};
      endcase
   endfunction

   function logic [15:0] level_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 16'($urandom_range(512, 1));
      if (r < 85) return 16'($urandom_range(4096, 513));
      if (r < 95) return 16'($urandom);
      return 16'd0;
   endfunction

   task send_item(input logic [1:0] op, input logic [2:0] lsel, input logic [9:0] addr,
                  input logic [63:0] data, input logic [31:0] scalar);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_level_sel  <= lsel;
      req_entry_addr <= addr;
      req_write_data <= data;
      req_scalar     <= scalar;
      do @(posedge clock); while (!req_ready);
      sb.note_item(op, lsel, addr, data, scalar);
      item_count++;
   endtask

   // fill whatever the lookup would touch unwritten, then issue it
   task lookup(input logic [31:0] scalar);
      miss_kind_type     miss;
      int                miss_addr;
      lookup_result_type res;
      sb.resolve(scalar, miss, miss_addr, res);
      while (miss != MISS_NONE) begin
         if (miss == MISS_KEY)
            send_item(OP_KEY, 3'(miss_addr / 1024), 10'(miss_addr % 1024), key_word(),
                      $urandom);
         else
            send_item(OP_RANK, 3'(miss_addr / 128), {3'($urandom), 7'(miss_addr % 128)},
                      {$urandom, $urandom}, $urandom);
         sb.resolve(scalar, miss, miss_addr, res);
      end
      send_item(OP_LOOKUP, 3'($urandom), 10'($urandom), {$urandom, $urandom}, scalar);
      seen_scalars.push_back(scalar);
   endtask

   task set_levels(input logic [LCOUNT_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.lcount = value;
   endtask

   task random_items(input int target);
      int r;
      while (item_count < target) begin
         r = $urandom_range(99);
         if (r < 50)
            lookup($urandom);
         else if (r < 65)
            send_item(OP_KEY, 3'($urandom), 10'($urandom), key_word(), $urandom);
         else if (r < 75)
            send_item(OP_RANK, 3'($urandom), 10'($urandom), {$urandom, $urandom}, $urandom);
         else if (r < 85)
            send_item(OP_SIZE, 3'($urandom), 10'($urandom),
                      {$urandom, 16'($urandom), level_size()}, $urandom);
         else if (seen_scalars.size() > 0)
            lookup(seen_scalars[$urandom_range(seen_scalars.size() - 1)]);
         else
            lookup($urandom);
      end
   endtask

   initial begin
      int                  target;
      int                  idle_pct[4];
      int                  stall_pct[4];
      logic [LCOUNT_W-1:0] lcounts[4];
      idle_pct  = '{0, 82, 0, 15};
      stall_pct = '{0, 0, 82, 15};
      lcounts   = '{4'd15, 4'd1, 4'd0, 4'd3};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_levels(4'd8);

      send_item(OP_SIZE, 3'd0, 10'd0, 64'd512, 32'd0);
      send_item(OP_SIZE, 3'd1, 10'h3FF, 64'hFFFF_FFFF_FFFF_0040, 32'hFFFF_FFFF);
      send_item(OP_SIZE, 3'd2, 10'd0, 64'd0, 32'd0);
      send_item(OP_SIZE, 3'd3, 10'd0, 64'd1, 32'd0);
      send_item(OP_SIZE, 3'd5, 10'd0, 64'd1024, 32'd0);
      send_item(OP_SIZE, 3'd7, 10'd0, 64'hFFFF, 32'd0);
      send_item(OP_KEY, 3'd7, 10'h3FF, '1, 32'hFFFF_FFFF);
      send_item(OP_KEY, 3'd7, 10'd0, 64'd0, 32'd0);
      send_item(OP_RANK, 3'd7, 10'h3FF, '1, 32'd0);
      send_item(OP_RANK, 3'd6, 10'h080, 64'd0, 32'd0);
      lookup(32'd0);
      lookup(32'hFFFF_FFFF);
      lookup(32'h8000_0000);
      lookup(32'd1);
      repeat (4) lookup($urandom);

      for (int p = 0; p < 4; p++) begin
         set_levels(lcounts[p]);
         send_idle_pct  = idle_pct[p];
         recv_stall_pct = stall_pct[p];
         target = item_count + 230;
         random_items(target);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (sb.errors == 0) begin
         $display("** mph_rank_index_lookup: PASSED **");
      end else begin
         $display("** mph_rank_index_lookup: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/mrl_pkg.sv
src/mph_rank_index_lookup.sv
test/tb.sv
